>>> rtl/core/wireframe_point_projection_top_defines.svh
// ----------------------------------------------------------------------------
// Wireframe point projection assertion macros
// Shared assertion forms for the port checker of the projection block.
// ----------------------------------------------------------------------------
`ifndef WIREFRAME_POINT_PROJECTION_TOP_DEFINES_SVH
`define WIREFRAME_POINT_PROJECTION_TOP_DEFINES_SVH

// Same-cycle implication, muted while reset is held.
`define WPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is held.
`define WPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define WPP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wpp_pkg.sv
// ----------------------------------------------------------------------------
// Wireframe point projection package
// Shared widths, register indexes, colors and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package wpp_pkg;

  // Default parameter values.
  localparam int MAP_DIM_DEF        = 1024;
  localparam int ANGLE_STEPS_DEF    = 1024;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Internal coordinate width; holds every rotated coordinate with margin.
  localparam int CW      = 28;
  localparam int OUT_W   = 21;
  localparam int COLOR_W = 24;
  localparam int ANG_W   = 10;

  // Pi in Q30 for the sine table build.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ZOOM         = 3'd0,
    REG_Z_SCALE      = 3'd1,
    REG_VIEW_ANGLES  = 3'd2,
    REG_MAP_SIZE     = 3'd3,
    REG_ORIGIN_X     = 3'd4,
    REG_ORIGIN_Y     = 3'd5,
    REG_HEIGHT_RANGE = 3'd6
  } reg_idx_t;

  // Height band colors.
  localparam logic [COLOR_W-1:0] COL_WHITE  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COL_BLUE   = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h00FF00;
  localparam logic [COLOR_W-1:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COL_ORANGE = 24'hFFA500;
  localparam logic [COLOR_W-1:0] COL_RED    = 24'hFF0000;

endpackage

`default_nettype wire

>>> rtl/core/wpp_trig.sv
// ----------------------------------------------------------------------------
// Wireframe point projection trig unit
// Registered sine and cosine of the three view angles from a quarter table.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_trig
  import wpp_pkg::*;
#(
  parameter int ANGLE_STEPS    = ANGLE_STEPS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic [3*ANG_W-1:0]             view_angles,
  output logic signed [TRIG_FRAC_BITS+1:0]    trig_o [6]
);

  localparam int SW      = TRIG_FRAC_BITS + 2;
  localparam int QUARTER = ANGLE_STEPS / 4;
  localparam int RW      = $clog2(ANGLE_STEPS);
  localparam int IW      = $clog2(QUARTER + 1);
  localparam int F       = TRIG_FRAC_BITS;

  logic [SW-1:0] sin_tab [QUARTER+1];
  logic [RW-1:0] ang_mod [3];

  // Quarter-wave sine table, Taylor series in Q30 rounded to nearest.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    localparam longint unsigned X   = (PI_Q30 * g) / (2 * QUARTER);
    localparam longint unsigned X2  = (X * X) >> 30;
    localparam longint unsigned T1  = ((X * X2) >> 30) / 6;
    localparam longint unsigned T2  = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3  = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4  = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5  = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6  = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7  = ((T6 * X2) >> 30) / 210;
    localparam longint unsigned T8  = ((T7 * X2) >> 30) / 272;
    localparam longint unsigned T9  = ((T8 * X2) >> 30) / 342;
    localparam longint unsigned T10 = ((T9 * X2) >> 30) / 420;
    localparam longint unsigned T11 = ((T10 * X2) >> 30) / 506;
    localparam longint unsigned T12 = ((T11 * X2) >> 30) / 600;
    localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
                           - longint'(T3) + longint'(T4) - longint'(T5)
                           + longint'(T6) - longint'(T7) + longint'(T8)
                           - longint'(T9) + longint'(T10) - longint'(T11)
                           + longint'(T12);
    localparam longint POS = (SUM < 0) ? 64'sd0 : SUM;
    localparam longint VAL = (POS + (64'sd1 <<< (29 - F))) >>> (30 - F);
    assign sin_tab[g] = SW'(VAL);
  end

  // Reduce each angle code modulo the step count.
  for (genvar j = 0; j < 3; j++) begin : g_mod
    if (ANGLE_STEPS >= (1 << ANG_W)) begin : g_id
      assign ang_mod[j] = RW'(view_angles[ANG_W*j +: ANG_W]);
    end else begin : g_rcp
      localparam int SH = 20;
      localparam int M  = ((1 << SH) + ANGLE_STEPS - 1) / ANGLE_STEPS;
      logic [31:0]      prod;
      logic [3:0]       quo;
      logic [ANG_W-1:0] rem;
      // Quotient by reciprocal; exact for codes below 2**ANG_W while the quotient fits in four bits.
      assign prod = 32'(view_angles[ANG_W*j +: ANG_W]) * 32'(M);
      assign quo  = prod[SH+3:SH];
      assign rem  = view_angles[ANG_W*j +: ANG_W] - ANG_W'(quo) * ANG_W'(ANGLE_STEPS);
      assign ang_mod[j] = rem[RW-1:0];
    end
  end

  // Sine for even slots, cosine (code plus a quarter) for odd slots.
  for (genvar i = 0; i < 6; i++) begin : g_look
    logic [RW:0]          csum;
    logic [RW-1:0]        code;
    logic [1:0]           quad;
    logic [RW-1:0]        rr;
    logic [IW-1:0]        idx;
    logic signed [SW-1:0] mag;

    always_comb begin
      csum = {1'b0, ang_mod[i/2]} + ((i % 2 == 1) ? (RW+1)'(QUARTER) : '0);
      if (csum >= (RW+1)'(ANGLE_STEPS)) begin
        code = RW'(csum - (RW+1)'(ANGLE_STEPS));
      end else begin
        code = RW'(csum);
      end
      if (code < RW'(QUARTER)) begin
        quad = 2'd0;
        rr   = code;
      end else if (code < RW'(2 * QUARTER)) begin
        quad = 2'd1;
        rr   = code - RW'(QUARTER);
      end else if (code < RW'(3 * QUARTER)) begin
        quad = 2'd2;
        rr   = code - RW'(2 * QUARTER);
      end else begin
        quad = 2'd3;
        rr   = code - RW'(3 * QUARTER);
      end
      if (quad[0]) begin
        idx = IW'(QUARTER) - IW'(rr);
      end else begin
        idx = IW'(rr);
      end
      mag = $signed(sin_tab[idx]);
    end

    always_ff @(posedge clk) begin
      trig_o[i] <= quad[1] ? -mag : mag;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wpp_scale.sv
// ----------------------------------------------------------------------------
// Wireframe point projection scale stage
// Zoom, height scale and map centering, plus the point color choice.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_scale
  import wpp_pkg::*;
#(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [9:0]                col,
  input  wire logic [9:0]                row,
  input  wire logic signed [15:0]        elevation,
  input  wire logic                      has_color,
  input  wire logic [COLOR_W-1:0]        given_color,
  input  wire logic [7:0]                zoom,
  input  wire logic [15:0]               z_scale,
  input  wire logic [21:0]               map_size,
  input  wire logic [31:0]               height_range,
  output logic                           v_r,
  output logic signed [CW-1:0]           x_r,
  output logic signed [CW-1:0]           y_r,
  output logic signed [CW-1:0]           z_r,
  output logic [COLOR_W-1:0]             color_r
);

  logic [11:0]          w_c, h_c;
  logic [17:0]          col_p, row_p;
  logic [19:0]          wz, hz;
  logic signed [19:0]   x_c, y_c;
  logic signed [32:0]   zp, zt;
  logic signed [15:0]   zmin, zmax;
  logic signed [16:0]   n0, d0;
  logic signed [17:0]   n1, d1;
  logic signed [20:0]   n5;
  logic [COLOR_W-1:0]   band;

  // Clamp the map size and center the scaled grid position.
  always_comb begin
    w_c = ({1'b0, map_size[10:0]} > 12'(MAP_DIM)) ? 12'(MAP_DIM) : {1'b0, map_size[10:0]};
    h_c = ({1'b0, map_size[21:11]} > 12'(MAP_DIM)) ? 12'(MAP_DIM) : {1'b0, map_size[21:11]};
    col_p = {8'd0, col} * {10'd0, zoom};
    row_p = {8'd0, row} * {10'd0, zoom};
    wz    = {8'd0, w_c} * {12'd0, zoom};
    hz    = {8'd0, h_c} * {12'd0, zoom};
    x_c   = $signed({2'b00, col_p}) - $signed({1'b0, wz[19:1]});
    y_c   = $signed({2'b00, row_p}) - $signed({1'b0, hz[19:1]});
  end

  // Elevation times Q8.8 scale, truncated toward zero.
  always_comb begin
    zp = 33'(elevation) * $signed({17'd0, z_scale});
    if (zp[32]) begin
      zt = (zp + 33'sd255) >>> 8;
    end else begin
      zt = zp >>> 8;
    end
  end

  // Height bands by exact integer compares of 5*n against k*d.
  always_comb begin
    zmin = $signed(height_range[15:0]);
    zmax = $signed(height_range[31:16]);
    n0   = 17'(elevation) - 17'(zmin);
    d0   = 17'(zmax) - 17'(zmin);
    n1   = d0[16] ? -18'(n0) : 18'(n0);
    d1   = d0[16] ? -18'(d0) : 18'(d0);
    n5   = 21'(n1) * 21'sd5;
    if (d0 == 17'sd0) begin
      band = COL_WHITE;
    end else if (n5 < 21'(d1)) begin
      band = COL_BLUE;
    end else if (n5 < 21'(d1) * 21'sd2) begin
      band = COL_GREEN;
    end else if (n5 < 21'(d1) * 21'sd3) begin
      band = COL_YELLOW;
    end else if (n5 < 21'(d1) * 21'sd4) begin
      band = COL_ORANGE;
    end else begin
      band = COL_RED;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= CW'(x_c);
      y_r     <= CW'(y_c);
      z_r     <= CW'(zt);
      color_r <= has_color ? given_color : band;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wpp_rotate.sv
// ----------------------------------------------------------------------------
// Wireframe point projection rotation stage
// Two-stage plane rotation (p, q) -> (p*c + q*s, q*c - p*s), truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_rotate
  import wpp_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int AUX_W          = CW + COLOR_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             v_i,
  input  wire logic signed [CW-1:0]             p_i,
  input  wire logic signed [CW-1:0]             q_i,
  input  wire logic [AUX_W-1:0]                 aux_i,
  input  wire logic signed [TRIG_FRAC_BITS+1:0] s_i,
  input  wire logic signed [TRIG_FRAC_BITS+1:0] c_i,
  output logic                                  v_o,
  output logic signed [CW-1:0]                  p_o,
  output logic signed [CW-1:0]                  q_o,
  output logic [AUX_W-1:0]                      aux_o
);

  localparam int SW = TRIG_FRAC_BITS + 2;
  localparam int PW = CW + SW;
  localparam logic signed [PW:0] BIAS = (PW+1)'((1 << TRIG_FRAC_BITS) - 1);

  logic                 v1_r;
  logic signed [PW-1:0] pc_r, qs_r, qc_r, ps_r;
  logic [AUX_W-1:0]     aux1_r;
  logic signed [PW:0]   sa, sb, ta, tb;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r   <= PW'(p_i) * PW'(c_i);
      qs_r   <= PW'(q_i) * PW'(s_i);
      qc_r   <= PW'(q_i) * PW'(c_i);
      ps_r   <= PW'(p_i) * PW'(s_i);
      aux1_r <= aux_i;
    end
  end

  // Sum and truncate toward zero.
  always_comb begin
    sa = (PW+1)'(pc_r) + (PW+1)'(qs_r);
    sb = (PW+1)'(qc_r) - (PW+1)'(ps_r);
    ta = sa[PW] ? ((sa + BIAS) >>> TRIG_FRAC_BITS) : (sa >>> TRIG_FRAC_BITS);
    tb = sb[PW] ? ((sb + BIAS) >>> TRIG_FRAC_BITS) : (sb >>> TRIG_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_o   <= CW'(ta);
      q_o   <= CW'(tb);
      aux_o <= aux1_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wireframe_point_projection_top.sv
// Throughput: one word per cycle; the eight-stage pipeline advances as one and
// freezes only while a result word waits on out_stall.
// Trig values follow a view_angles write through view_angles_r and the registered trig outputs.
// Reset: synchronous, active low; clears pipeline valids and loads register defaults.
// ----------------------------------------------------------------------------
// Wireframe point projection top level
// Scales, centers and rotates grid points about X, Y and Z for screen output.
// ----------------------------------------------------------------------------
`default_nettype none

module wireframe_point_projection_top
  import wpp_pkg::*;
#(
  parameter int MAP_DIM        = MAP_DIM_DEF,
  parameter int ANGLE_STEPS    = ANGLE_STEPS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [9:0]               in_col,
  input  wire logic [9:0]               in_row,
  input  wire logic signed [15:0]       in_elevation,
  input  wire logic                     in_has_color,
  input  wire logic [COLOR_W-1:0]       in_given_color,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [OUT_W-1:0]       out_screen_x,
  output logic signed [OUT_W-1:0]       out_screen_y,
  output logic signed [OUT_W-1:0]       out_depth,
  output logic [COLOR_W-1:0]            out_color,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [31:0]              cfg_data
);

  localparam int SW    = TRIG_FRAC_BITS + 2;
  localparam int AUX_W = CW + COLOR_W;

  logic [7:0]             zoom_r;
  logic [15:0]            z_scale_r;
  logic [3*ANG_W-1:0]     view_angles_r;
  logic [21:0]            map_size_r;
  logic signed [15:0]     origin_x_r, origin_y_r;
  logic [31:0]            height_range_r;

  logic                   en;
  logic signed [SW-1:0]   trig [6];

  logic                   v1;
  logic signed [CW-1:0]   x1, y1, z1;
  logic [COLOR_W-1:0]     c1;

  logic                   vx, vy, vz;
  logic signed [CW-1:0]   yx, zx, xy, zy, yz, xz;
  logic [AUX_W-1:0]       aux_x, aux_y, aux_z;

  logic signed [CW:0]     sx, sy;
  logic                   out_valid_r;
  logic signed [OUT_W-1:0] sx_r, sy_r, depth_r;
  logic [COLOR_W-1:0]     color_r;

  // Saturate a coordinate to the output range.
  function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [CW:0] v);
    logic signed [CW:0] hi, lo;
    hi = (CW+1)'((1 << (OUT_W - 1)) - 1);
    lo = -(CW+1)'(1 << (OUT_W - 1));
    if (v > hi) begin
      return OUT_W'(hi);
    end else if (v < lo) begin
      return OUT_W'(lo);
    end
    return OUT_W'(v);
  endfunction

  // Configuration register writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r         <= 8'd20;
      z_scale_r      <= 16'd256;
      view_angles_r  <= '0;
      map_size_r     <= '0;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      height_range_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ZOOM:         zoom_r         <= cfg_data[7:0];
        REG_Z_SCALE:      z_scale_r      <= cfg_data[15:0];
        REG_VIEW_ANGLES:  view_angles_r  <= cfg_data[3*ANG_W-1:0];
        REG_MAP_SIZE:     map_size_r     <= cfg_data[21:0];
        REG_ORIGIN_X:     origin_x_r     <= $signed(cfg_data[15:0]);
        REG_ORIGIN_Y:     origin_y_r     <= $signed(cfg_data[15:0]);
        REG_HEIGHT_RANGE: height_range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the result word is held.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Sine and cosine of the view angles.
  wpp_trig #(
    .ANGLE_STEPS    (ANGLE_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk         (clk),
    .view_angles (view_angles_r),
    .trig_o      (trig)
  );

  // Scale, center and color.
  wpp_scale #(
    .MAP_DIM (MAP_DIM)
  ) u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_v         (in_valid),
    .col          (in_col),
    .row          (in_row),
    .elevation    (in_elevation),
    .has_color    (in_has_color),
    .given_color  (in_given_color),
    .zoom         (zoom_r),
    .z_scale      (z_scale_r),
    .map_size     (map_size_r),
    .height_range (height_range_r),
    .v_r          (v1),
    .x_r          (x1),
    .y_r          (y1),
    .z_r          (z1),
    .color_r      (c1)
  );

  // Rotation about X acts on (y, z).
  wpp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .AUX_W          (AUX_W)
  ) u_rot_x (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (v1),
    .p_i   (y1),
    .q_i   (z1),
    .aux_i ({x1, c1}),
    .s_i   (trig[0]),
    .c_i   (trig[1]),
    .v_o   (vx),
    .p_o   (yx),
    .q_o   (zx),
    .aux_o (aux_x)
  );

  // Rotation about Y acts on (x, z).
  wpp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .AUX_W          (AUX_W)
  ) u_rot_y (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (vx),
    .p_i   (aux_x[AUX_W-1:COLOR_W]),
    .q_i   (zx),
    .aux_i ({yx, aux_x[COLOR_W-1:0]}),
    .s_i   (trig[2]),
    .c_i   (trig[3]),
    .v_o   (vy),
    .p_o   (xy),
    .q_o   (zy),
    .aux_o (aux_y)
  );

  // Rotation about Z acts on (y, x).
  wpp_rotate #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .AUX_W          (AUX_W)
  ) u_rot_z (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (vy),
    .p_i   (aux_y[AUX_W-1:COLOR_W]),
    .q_i   (xy),
    .aux_i ({zy, aux_y[COLOR_W-1:0]}),
    .s_i   (trig[4]),
    .c_i   (trig[5]),
    .v_o   (vz),
    .p_o   (yz),
    .q_o   (xz),
    .aux_o (aux_z)
  );

  // Screen origin and output saturation.
  assign sx = (CW+1)'(xz) + (CW+1)'(origin_x_r);
  assign sy = (CW+1)'(yz) + (CW+1)'(origin_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r    <= sat_coord(sx);
      sy_r    <= sat_coord(sy);
      depth_r <= sat_coord((CW+1)'($signed(aux_z[AUX_W-1:COLOR_W])));
      color_r <= aux_z[COLOR_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;
  assign out_depth    = depth_r;
  assign out_color    = color_r;

endmodule

`default_nettype wire

>>> rtl/core/wpp_checker.sv
// ----------------------------------------------------------------------------
// Wireframe point projection port checker
// Checks stall, configuration and reset behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wireframe_point_projection_top_defines.svh"

module wpp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  // The input only stalls while a result word is held at the output.
  `WPP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without held word")

  // Configuration writes are never refused.
  `WPP_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

  // Reset empties the output.
  `WPP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result word after reset")

  // A held result word stays offered.
  `WPP_ASSERT_NXT(a_hold_valid, out_valid && out_stall, out_valid, "held word dropped")

endmodule

bind wireframe_point_projection_top wpp_checker u_wpp_checker (.*);

`default_nettype wire

>>> dv/wireframe_point_projection_top_tb.sv
// ----------------------------------------------------------------------------
// Wireframe point projection testbench
// Drives grid points through the projector under several register settings,
// with random idling on both sides. Each result word is checked field by field
// against a software model of scaling, centering, rotation and color banding.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the register copy and the queue of projected points still awaited.
class projection_board;
  typedef struct {
    logic signed [20:0] sx;
    logic signed [20:0] sy;
    logic signed [20:0] dz;
    logic [23:0]        rgb;
  } point_t;

  point_t      pending_points[$];
  int          sine_q[0:256];
  logic [7:0]  zoom;
  logic [15:0] z_scale;
  logic [29:0] angles;
  logic [21:0] map_size;
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic [31:0] hrange;
  int          mismatches;

  function new();
    longint unsigned x, x2, term;
    longint          sum;
    mismatches = 0;
    // Quarter-wave sine table in Q1.14, Taylor series in Q30.
    for (int i = 0; i <= 256; i++) begin
      x = (64'd3373259426 * i) / 512;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      sine_q[i] = int'((longint'(sum) + (64'd1 << 15)) >> 16);
    end
    set_defaults();
  endfunction

  function void set_defaults();
    zoom = 20; z_scale = 256; angles = 0; map_size = 0;
    org_x = 0; org_y = 0; hrange = 0;
  endfunction

  function void write_reg(wpp_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      wpp_pkg::REG_ZOOM:         zoom = v[7:0];
      wpp_pkg::REG_Z_SCALE:      z_scale = v[15:0];
      wpp_pkg::REG_VIEW_ANGLES:  angles = v[29:0];
      wpp_pkg::REG_MAP_SIZE:     map_size = v[21:0];
      wpp_pkg::REG_ORIGIN_X:     org_x = v[15:0];
      wpp_pkg::REG_ORIGIN_Y:     org_y = v[15:0];
      wpp_pkg::REG_HEIGHT_RANGE: hrange = v;
      default: ;
    endcase
  endfunction

  function longint sine_of(int a);
    int r;
    a = a % 1024;
    r = a % 256;
    case (a / 256)
      0: return sine_q[r];
      1: return sine_q[256 - r];
      2: return -sine_q[r];
      default: return -sine_q[256 - r];
    endcase
  endfunction

  // Rotates (p, q) by angle code a, truncating toward zero.
  function void turn(ref longint p, ref longint q, input int a);
    longint s, c, pa, qb;
    s = sine_of(a);
    c = sine_of(a % 1024 + 256);
    pa = p; qb = q;
    p = (pa * c + qb * s) / 16384;
    q = (qb * c - pa * s) / 16384;
  endfunction

  function logic [20:0] clip21(longint v);
    if (v > 1048575) v = 1048575;
    if (v < -1048576) v = -1048576;
    return v[20:0];
  endfunction

  function logic [23:0] band_of(longint z);
    longint n, d;
    n = z - longint'($signed(hrange[15:0]));
    d = longint'($signed(hrange[31:16])) - longint'($signed(hrange[15:0]));
    if (d == 0) return wpp_pkg::COL_WHITE;
    if (d < 0) begin
      n = -n; d = -d;
    end
    if (5 * n < d) return wpp_pkg::COL_BLUE;
    if (5 * n < 2 * d) return wpp_pkg::COL_GREEN;
    if (5 * n < 3 * d) return wpp_pkg::COL_YELLOW;
    if (5 * n < 4 * d) return wpp_pkg::COL_ORANGE;
    return wpp_pkg::COL_RED;
  endfunction

  // Notes an accepted grid point and queues its projection.
  function void note_point(logic [9:0] col, logic [9:0] row, logic signed [15:0] elev,
                           logic has_c, logic [23:0] given);
    longint w, h, x, y, z, nx, ny;
    point_t p;
    w = map_size[10:0]; h = map_size[21:11];
    if (w > 1024) w = 1024;
    if (h > 1024) h = 1024;
    // Keep all terms signed so negative values divide toward zero.
    x = longint'(col) * longint'(zoom) - (w * longint'(zoom)) / 2;
    y = longint'(row) * longint'(zoom) - (h * longint'(zoom)) / 2;
    z = (longint'(elev) * longint'(z_scale)) / 256;
    turn(y, z, angles[9:0]);
    turn(x, z, angles[19:10]);
    ny = y; nx = x;
    turn(ny, nx, angles[29:20]);
    x = nx + longint'($signed(org_x));
    y = ny + longint'($signed(org_y));
    p.sx = clip21(x); p.sy = clip21(y); p.dz = clip21(z);
    p.rgb = has_c ? given : band_of(elev);
    pending_points.push_back(p);
  endfunction

  // Compares one result word with the oldest queued projection.
  function void check_point(logic [20:0] sx, logic [20:0] sy, logic [20:0] dz,
                            logic [23:0] rgb);
    point_t e;
    if (pending_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result word with none expected");
      return;
    end
    e = pending_points.pop_front();
    if (sx !== e.sx || sy !== e.sy || dz !== e.dz || rgb !== e.rgb) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: exp x=%0d y=%0d z=%0d c=%h got x=%0d y=%0d z=%0d c=%h",
                 e.sx, e.sy, e.dz, e.rgb, $signed(sx), $signed(sy), $signed(dz), rgb);
    end
  endfunction
endclass

module wireframe_point_projection_top_tb;
  import wpp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [9:0]         in_col = '0;
  logic [9:0]         in_row = '0;
  logic signed [15:0] in_elevation = '0;
  logic               in_has_color = 1'b0;
  logic [23:0]        in_given_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [20:0] out_screen_x, out_screen_y, out_depth;
  logic [23:0]        out_color;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  projection_board board;
  bit              idle_on = 1'b1;
  int              cycles = 0;

  wireframe_point_projection_top i_dut (.*);

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result receiver with bursty stall.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_point(out_screen_x, out_screen_y, out_depth, out_color);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sends one grid point word, with an optional idle burst ahead of it.
  task automatic send_point(logic [9:0] c, logic [9:0] r, logic [15:0] e, logic hc,
                            logic [23:0] g);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col <= c; in_row <= r; in_elevation <= e;
    in_has_color <= hc; in_given_color <= g;
    do @(posedge clk); while (in_stall);
    board.note_point(c, r, e, hc, g);
  endtask

  task automatic send_random();
    logic [15:0] e;
    case ($urandom_range(0, 3))
      0: e = 16'h8000;
      1: e = 16'h7FFF;
      default: e = 16'($urandom);
    endcase
    send_point(10'($urandom), 10'($urandom), e, $urandom_range(0, 3) == 0,
               24'($urandom));
  endtask

  // Lets the pipeline drain before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] z, logic [31:0] s, logic [31:0] a, logic [31:0] m,
                           logic [31:0] ox, logic [31:0] oy, logic [31:0] hr);
    drain();
    write_reg(REG_ZOOM, z);
    write_reg(REG_Z_SCALE, s);
    write_reg(REG_VIEW_ANGLES, a);
    write_reg(REG_MAP_SIZE, m);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_HEIGHT_RANGE, hr);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults (flat range gives white), field extremes, stored color.
    send_point(0, 0, 0, 0, 0);
    send_point(10'h3FF, 10'h3FF, 16'h7FFF, 0, 0);
    send_point(10'h3FF, 0, 16'h8000, 1, 24'hFFFFFF);
    send_point(0, 10'h3FF, 16'h0001, 1, 24'h000000);
    // Height bands over 0..100, map clamp, non-zero angles.
    write_all(1, 256, {10'd0, 10'd0, 10'd256}, {11'd2047, 11'd2047}, 16'h7FFF, 16'h8000,
              {16'd100, 16'd0});
    for (int k = -1; k <= 101; k += 17) send_point(5, 5, 16'(k), 0, 0);
    send_point(0, 0, 20, 0, 0);
    send_point(0, 0, 40, 0, 0);
    send_point(0, 0, 80, 0, 0);
    // Reversed range, zero zoom, every angle code at its maximum.
    write_all(0, 65535, 30'h3FFFFFFF, 22'd0, 16'h8000, 16'h7FFF, {16'hFF9C, 16'd100});
    for (int k = -120; k <= 120; k += 40) send_point(1, 1, 16'(k), 0, 0);
    send_point(10'h3FF, 10'h3FF, 16'h8000, 0, 0);

    // Random phases with varied settings; extremes recur through $urandom.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_on = 1'b0;
      write_all(ph == 0 ? 255 : $urandom_range(0, 255),
                ph == 1 ? 0 : $urandom_range(0, 65535), $urandom, $urandom, $urandom,
                $urandom, $urandom);
      for (int n = 0; n < 250; n++) begin
        send_random();
        // Hold back until the pipeline is empty once per phase.
        if (n == 100)
          drain();
      end
    end

    in_valid <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/wpp_pkg.sv
rtl/core/wpp_trig.sv
rtl/core/wpp_scale.sv
rtl/core/wpp_rotate.sv
rtl/core/wireframe_point_projection_top.sv
rtl/core/wpp_checker.sv
dv/wireframe_point_projection_top_tb.sv
